FILE: sv/idt_pkg.sv
// shared types and constants of the indent/dedent tracker
`default_nettype none

package idt_pkg;

  // field widths of the line and token channels
  localparam int MODE_W  = 2;
  localparam int IN_W    = 8;
  localparam int KIND_W  = 3;
  localparam int DEPTH_W = 6;

  // level stack geometry
  localparam int STACK_ENTRIES = 64;
  localparam int STACK_AW      = 6;
  localparam int HARD_DEPTH    = 62;

  // parameter defaults
  localparam int MAX_DEPTH_DEF  = 63;
  localparam int WIDTH_BITS_DEF = 8;

  // line kinds
  localparam logic [MODE_W-1:0] MODE_CONTENT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLANK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END     = 2'd2;

  // token kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SAME     = 3'd0,
    KIND_INDENT   = 3'd1,
    KIND_DEDENT   = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_BLANK    = 3'd4,
    KIND_END      = 3'd5
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic  capture;
    logic  push;
    logic  pop_rd;
    logic  pop;
    logic  end_pop;
    logic  end_clear;
    logic  emit;
    kind_e emit_kind;
    logic  emit_last;
  } idt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              w_gt_top;
    logic              w_lt_top;
    logic              full;
    logic              open_zero;
    logic              next_gt_w;
    logic              out_free;
  } idt_sts_t;

endpackage

`default_nettype wire

FILE: sv/idt_in_if.sv
// line channel: one beat per source line
`default_nettype none

interface idt_in_if import idt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IN_W-1:0]   indent_width;

  modport source (output valid, output mode, output indent_width, input ready);
  modport sink   (input valid, input mode, input indent_width, output ready);
endinterface

`default_nettype wire

FILE: sv/idt_out_if.sv
// token channel: one beat per result
`default_nettype none

interface idt_out_if import idt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [DEPTH_W-1:0] level_depth;
  logic               last;

  modport source (output valid, output token_kind, output level_depth, output last,
                  input ready);
  modport sink   (input valid, input token_kind, input level_depth, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/idt_ctrl.sv
// sequencer of the indent/dedent tracker
`default_nettype none

module idt_ctrl import idt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire idt_sts_t sts_i,
  output idt_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_POP_RD,
    S_POP_CHK,
    S_END_POP
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_kind = KIND_SAME;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        case (sts_i.mode)
          MODE_END: begin
            state_d = S_END_POP;
          end
          MODE_CONTENT: begin
            if (sts_i.w_lt_top) begin
              state_d = S_POP_RD;
            end else if (sts_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              state_d         = S_IDLE;
              if (!sts_i.w_gt_top) begin
                cmd_o.emit_kind = KIND_SAME;
              end else if (sts_i.full) begin
                cmd_o.emit_kind = KIND_OVERFLOW;
              end else begin
                cmd_o.emit_kind = KIND_INDENT;
                cmd_o.push      = 1'b1;
              end
            end
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = KIND_BLANK;
              cmd_o.emit_last = 1'b1;
              state_d         = S_IDLE;
            end
          end
        endcase
      end
      S_POP_RD: begin
        // fetch the level below the top
        cmd_o.pop_rd = 1'b1;
        state_d      = S_POP_CHK;
      end
      S_POP_CHK: begin
        if (sts_i.out_free) begin
          cmd_o.pop       = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_DEDENT;
          cmd_o.emit_last = !sts_i.next_gt_w;
          state_d         = sts_i.next_gt_w ? S_POP_RD : S_IDLE;
        end
      end
      S_END_POP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.open_zero) begin
            cmd_o.emit_kind = KIND_END;
            cmd_o.emit_last = 1'b1;
            cmd_o.end_clear = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.emit_kind = KIND_DEDENT;
            cmd_o.end_pop   = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/idt_dp.sv
// level stack, compare logic and token register of the tracker
`default_nettype none

module idt_dp import idt_pkg::*; #(
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [MODE_W-1:0]  mode_i,
  input  wire logic [IN_W-1:0]    indent_width_i,
  input  wire idt_cmd_t           cmd_i,
  output idt_sts_t                sts_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [KIND_W-1:0]       token_kind_o,
  output logic [DEPTH_W-1:0]      level_depth_o,
  output logic                    last_o
);

  localparam int CW = (WIDTH_BITS > IN_W) ? WIDTH_BITS : IN_W;
  localparam logic [CW-1:0] WMAX = CW'((32'd1 << WIDTH_BITS) - 32'd1);

  logic [WIDTH_BITS-1:0] stack_mem [STACK_ENTRIES];

  logic [MODE_W-1:0]     mode_q;
  logic [WIDTH_BITS-1:0] w_q;
  logic [WIDTH_BITS-1:0] top_q, top_d;
  logic [DEPTH_W-1:0]    open_q, open_d;
  logic [WIDTH_BITS-1:0] rd_data_q;
  logic                  rd_zero_q;
  logic                  out_valid_q;
  kind_e                 kind_q;
  logic [DEPTH_W-1:0]    depth_q;
  logic                  last_q;

  logic [CW-1:0]         w_ext;
  logic [CW-1:0]         w_sat;
  logic [8:0]            open_plus;
  logic [WIDTH_BITS-1:0] next_val;
  logic [STACK_AW-1:0]   wr_addr;
  logic [STACK_AW-1:0]   rd_addr;

  // saturate the incoming width to the level range
  assign w_ext = CW'(indent_width_i);
  assign w_sat = (w_ext > WMAX) ? WMAX : w_ext;

  // level under the top, entry zero reads as zero
  assign next_val  = rd_zero_q ? '0 : rd_data_q;
  assign open_plus = 9'(open_q) + 9'd1;
  assign wr_addr   = STACK_AW'(open_q + 1'b1);
  assign rd_addr   = STACK_AW'(open_q - 1'b1);

  // status toward the sequencer
  always_comb begin
    sts_o.mode      = mode_q;
    sts_o.w_gt_top  = (w_q > top_q);
    sts_o.w_lt_top  = (w_q < top_q);
    sts_o.full      = (open_plus >= 9'(MAX_DEPTH)) || (open_q >= DEPTH_W'(HARD_DEPTH));
    sts_o.open_zero = (open_q == '0);
    sts_o.next_gt_w = (next_val > w_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // depth and top-of-stack update
  always_comb begin
    open_d = open_q;
    top_d  = top_q;
    if (cmd_i.push) begin
      open_d = open_q + 1'b1;
      top_d  = w_q;
    end else if (cmd_i.pop) begin
      open_d = open_q - 1'b1;
      top_d  = next_val;
    end else if (cmd_i.end_pop) begin
      open_d = open_q - 1'b1;
    end else if (cmd_i.end_clear) begin
      top_d  = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      open_q <= open_d;
      top_q  <= top_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // line capture and token payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      w_q    <= w_sat[WIDTH_BITS-1:0];
    end
    if (cmd_i.emit) begin
      kind_q  <= cmd_i.emit_kind;
      depth_q <= open_d;
      last_q  <= cmd_i.emit_last;
    end
  end

  // level stack memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_mem[wr_addr] <= w_q;
    end
    if (cmd_i.pop_rd) begin
      rd_data_q <= stack_mem[rd_addr];
      rd_zero_q <= (open_q == DEPTH_W'(1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = kind_q;
  assign level_depth_o = depth_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

FILE: sv/indent_dedent_tracker_unit.sv
// Indentation tracker: one line beat in, one or more token beats out.
// A line beat is taken only in idle and is evaluated once captured; a single token is then
// registered from the evaluate state. End of input emits one dedent per open level and then
// the end marker; a dedent run does one stack read per popped level before each dedent.
// Tokens wait for a free output register; a new line is taken once the last token is loaded.
// Reset clears depth, top level and sequencer; the stack memory is not cleared.
`default_nettype none

module indent_dedent_tracker_unit import idt_pkg::*; #(
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  idt_in_if.sink    line_i,
  idt_out_if.source tok_o
);

  idt_cmd_t cmd;
  idt_sts_t sts;

  // sequencer
  idt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (line_i.valid),
    .in_ready_o (line_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stack and token datapath
  idt_dp #(
    .MAX_DEPTH  (MAX_DEPTH),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (line_i.mode),
    .indent_width_i (line_i.indent_width),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (tok_o.ready),
    .out_valid_o    (tok_o.valid),
    .token_kind_o   (tok_o.token_kind),
    .level_depth_o  (tok_o.level_depth),
    .last_o         (tok_o.last)
  );

  // a token is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("token loaded over a waiting beat");

  // a push never happens at the depth limit
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.full)
    else $error("push at the depth limit");

  // only dedents may be followed by more tokens of the same line
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.valid && !tok_o.last) |-> (tok_o.token_kind == KIND_DEDENT))
    else $error("non-final token that is not a dedent");

  // the end marker leaves no open level
  a_end_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.valid && tok_o.token_kind == KIND_END) |-> (tok_o.level_depth == '0))
    else $error("end marker with open levels");

endmodule

`default_nettype wire
